// ----- hw/rtl/sha_pkg.sv -----
// SHA-256 package: round constants, initial hash values, a rotate function
// and controller/datapath command and status structs. No dependencies.
package sha_pkg;
	localparam int unsigned WordW = 32;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		BSRC_DATA = 2'd0,
		BSRC_PAD = 2'd1,
		BSRC_ZERO = 2'd2,
		BSRC_LEN = 2'd3
	} bsrc_t;

	typedef struct packed {
		logic put;          // write one byte into the block
		bsrc_t src;
		logic [2:0] len_idx; // length byte, 0 is most significant
		logic add_len;      // count eight more message bits
		logic comp_start;   // load schedule and working variables
		logic round_en;     // run one round
		logic [5:0] round;
		logic fold;         // add working variables into chain
		logic msg_clear;    // back to initial hash, clear length
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} dp_sts_t;

	localparam word_t H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction
endpackage

// ----- hw/rtl/sha256_stream_hasher.sv -----
// SHA-256 stream hasher top level: byte stream in, digest words out.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Usage:
//   s_axis carries one item per handshake: tdata = data_byte, tuser =
//   byte_valid, tlast = end_of_message. A byte with byte_valid clear adds
//   nothing; with tlast it still closes the message (empty message allowed).
//   m_axis carries the digest: eight items, most significant word first,
//   tdata = digest_word, tuser = word_index, tlast on the eighth word.
// Throughput: a byte that does not fill a block is taken in idle with no
//   compression. The 64th byte of a block starts a compression (load, 64
//   rounds on the single round unit, fold) before the next item is taken. The end item runs
//   padding one byte a cycle plus one or two compressions, then the digest
//   words follow one per accepted output handshake.
// Reset: asynchronous, active low; chain value returns to the initial hash,
//   length and fill clear. Block and schedule storage need no clearing.
// Stall: while m_axis_tready is low the current digest word is held and no
//   input item is taken; a new message is accepted after the eighth word.
module sha256_stream_hasher (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] data_byte
	input logic [0:0] s_axis_tuser, // [0] byte_valid
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [31:0] digest_word
	output logic [2:0] m_axis_tuser, // [2:0] word_index
	output logic m_axis_tlast
);
	sha_pkg::dp_cmd_t cmd;
	sha_pkg::dp_sts_t sts;
	logic in_fire, out_fire;
	logic [2:0] idx;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_byte_valid(s_axis_tuser[0]), .in_end(s_axis_tlast), .sts(sts),
		.out_fire(out_fire), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
		.out_idx(idx), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(s_axis_tdata),
		.rd_idx(idx), .sts(sts), .rd_word(m_axis_tdata)
	);

	assign m_axis_tuser = idx;
	assign m_axis_tlast = (idx == 3'd7);

	// Never take an input item while a digest is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
	// Each digest word index advances by one per accepted word.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && idx != 3'd7) |=> (m_axis_tvalid && idx == $past(idx) + 3'd1))
		else $error("word index skipped");
	// After the final word the block returns to accepting input.
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tlast) |=> s_axis_tready) else $error("no return to idle");
endmodule

// ----- hw/rtl/sha_datapath.sv -----
// SHA-256 datapath: block buffer, length counter, chain value, schedule
// window and one-round-per-cycle compression unit. Uses sha_pkg.
module sha_datapath (
	input logic clk,
	input logic arst_n,
	input sha_pkg::dp_cmd_t cmd,
	input logic [7:0] data_byte,
	input logic [2:0] rd_idx,
	output sha_pkg::dp_sts_t sts,
	output sha_pkg::word_t rd_word
);
	sha_pkg::word_t blk_q [16];
	sha_pkg::word_t w_q [16];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t chain_q [8];
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [7:0] bval;
	sha_pkg::word_t wt, wnew, g0, g1, s0, s1, chv, mj, t1, t2;
	logic [3:0] slot;

	always_comb begin
		case (cmd.src)
			sha_pkg::BSRC_DATA: bval = data_byte;
			sha_pkg::BSRC_PAD: bval = 8'h80;
			sha_pkg::BSRC_LEN: bval = bits_q[8'(7 - cmd.len_idx) * 8 +: 8];
			default: bval = 8'h00;
		endcase
	end

	assign slot = cmd.round[3:0];
	assign g0 = sha_pkg::rotr(w_q[4'(slot + 4'd1)], 7) ^ sha_pkg::rotr(w_q[4'(slot + 4'd1)], 18)
		^ (w_q[4'(slot + 4'd1)] >> 3);
	assign g1 = sha_pkg::rotr(w_q[4'(slot + 4'd14)], 17)
		^ sha_pkg::rotr(w_q[4'(slot + 4'd14)], 19) ^ (w_q[4'(slot + 4'd14)] >> 10);
	assign wnew = w_q[slot] + g0 + w_q[4'(slot + 4'd9)] + g1;
	assign wt = (cmd.round < 6'd16) ? w_q[slot] : wnew;
	assign s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
	assign chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + s1 + chv + sha_pkg::K[cmd.round] + wt;
	assign s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = s0 + mj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::H0[i];
		end else begin
			if (cmd.put) fill_q <= fill_q + 6'd1;
			if (cmd.add_len) bits_q <= bits_q + 64'd8;
			if (cmd.fold)
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			if (cmd.msg_clear) begin
				fill_q <= '0;
				bits_q <= '0;
				for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::H0[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put)
			blk_q[fill_q[5:2]][8'(3 - fill_q[1:0]) * 8 +: 8] <= bval;
		if (cmd.comp_start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (cmd.round_en) begin
			w_q[slot] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign sts.fill = fill_q;
	assign rd_word = chain_q[rd_idx];
endmodule

// ----- hw/rtl/sha_ctrl.sv -----
// SHA-256 controller: sequences byte writes, padding, compression rounds
// and digest readout. Uses sha_pkg; drives sha_datapath.
module sha_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic in_byte_valid,
	input logic in_end,
	input sha_pkg::dp_sts_t sts,
	input logic out_fire,
	output logic in_ready,
	output logic out_valid,
	output logic [2:0] out_idx,
	output sha_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_OUT
	} state_t;

	state_t state_q;
	logic [5:0] round_q;
	logic ending_q;
	logic [2:0] idx_q;
	// padding_q: in padding phase; wrap_q: 0x80 landed in the length field,
	// so this block ends in zeros; len_done_q: length bytes written in the
	// last block, so the next fold finishes the message
	logic padding_q, wrap_q, len_done_q;
	logic len_byte;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_idx = idx_q;

	// length bytes go only into the final block, at positions 56..63
	assign len_byte = (state_q == S_PAD) && !ending_q && !wrap_q && (sts.fill >= 6'd56);

	always_comb begin
		cmd = '0;
		cmd.round = round_q;
		cmd.len_idx = sts.fill[2:0];
		case (state_q)
			S_IDLE: begin
				cmd.put = in_fire && in_byte_valid;
				cmd.add_len = in_fire && in_byte_valid;
				cmd.src = sha_pkg::BSRC_DATA;
			end
			S_START: cmd.comp_start = 1'b1;
			S_ROUND: cmd.round_en = 1'b1;
			S_FOLD: cmd.fold = 1'b1;
			S_PAD: begin
				cmd.put = 1'b1;
				if (ending_q) cmd.src = sha_pkg::BSRC_PAD;
				else if (len_byte) cmd.src = sha_pkg::BSRC_LEN;
				else cmd.src = sha_pkg::BSRC_ZERO;
			end
			S_OUT: cmd.msg_clear = out_fire && (idx_q == 3'd7);
			default: ;
		endcase
	end

	// ending_q: padding byte 0x80 still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
			ending_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					ending_q <= in_end;
					if (in_byte_valid && sts.fill == 6'd63) state_q <= S_START;
					else if (in_end) state_q <= S_PAD;
				end
				S_START: begin
					round_q <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (len_done_q) state_q <= S_OUT;
					else if (ending_q || padding_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_PAD: begin
					ending_q <= 1'b0;
					if (sts.fill == 6'd63) state_q <= S_START;
				end
				S_OUT: if (out_fire) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			padding_q <= 1'b0;
			wrap_q <= 1'b0;
			len_done_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && in_fire && in_end) padding_q <= 1'b1;
			if (state_q == S_PAD) begin
				if (sts.fill == 6'd63) wrap_q <= 1'b0;
				else if (ending_q && sts.fill >= 6'd56) wrap_q <= 1'b1;
				if (len_byte && sts.fill == 6'd63) len_done_q <= 1'b1;
			end
			if (state_q == S_FOLD && len_done_q) begin
				padding_q <= 1'b0;
				len_done_q <= 1'b0;
			end
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for sha256_stream_hasher: byte items in, digest words out.
// Depends on sha_pkg (initial hash, round constants) and the hasher RTL.
module tb_top;
	typedef struct packed {
		logic [7:0] data_byte;
		logic byte_valid;
		logic end_of_message;
	} byte_item_t;

	typedef struct packed {
		sha_pkg::word_t digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_item_t;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	sha256_stream_hasher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// predictor state
	sha_pkg::word_t hash_state [8];
	sha_pkg::word_t msg_block [16];
	int unsigned block_bytes;
	logic [63:0] bit_count;

	byte_item_t pending_bytes[$];
	digest_item_t expected_digest[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	bit in_taken = 1'b0;
	int mismatches = 0;
	int stall_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic sha_pkg::word_t big_sigma(sha_pkg::word_t x, int a, int b, int c);
		return sha_pkg::rotr(x, a) ^ sha_pkg::rotr(x, b) ^ sha_pkg::rotr(x, c);
	endfunction

	task automatic compress();
		sha_pkg::word_t w [64];
		sha_pkg::word_t v [8];
		sha_pkg::word_t t1, t2;
		for (int r = 0; r < 16; r++) w[r] = msg_block[r];
		for (int r = 16; r < 64; r++) begin
			w[r] = w[r-16] + w[r-7]
				+ (sha_pkg::rotr(w[r-15], 7) ^ sha_pkg::rotr(w[r-15], 18) ^ (w[r-15] >> 3))
				+ (sha_pkg::rotr(w[r-2], 17) ^ sha_pkg::rotr(w[r-2], 19) ^ (w[r-2] >> 10));
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + big_sigma(v[4], 6, 11, 25) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
				+ sha_pkg::K[r] + w[r];
			t2 = big_sigma(v[0], 2, 13, 22) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic absorb(logic [7:0] b);
		int unsigned wi;
		wi = block_bytes / 4;
		if (block_bytes % 4 == 0) msg_block[wi] = '0;
		msg_block[wi] |= sha_pkg::word_t'(b) << ((3 - block_bytes % 4) * 8);
		block_bytes++;
		if (block_bytes == 64) begin
			compress();
			block_bytes = 0;
		end
	endtask

	// advance the predictor by one accepted item; queue the digest on end
	task automatic hash_item(byte_item_t it);
		digest_item_t d;
		if (it.byte_valid) begin
			absorb(it.data_byte);
			bit_count += 64'd8;
		end
		if (!it.end_of_message) return;
		absorb(8'h80);
		while (block_bytes != 56) absorb(8'h00);
		for (int i = 7; i >= 0; i--) absorb(bit_count[i*8 +: 8]);
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_state[i];
			d.word_index = 3'(i);
			d.last_word = (i == 7);
			expected_digest = {expected_digest, d};
		end
		hash_state = sha_pkg::H0;
		block_bytes = 0;
		bit_count = '0;
	endtask

	task automatic queue_message(int len, int mode);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data_byte = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
			it.byte_valid = 1'b1;
			it.end_of_message = 1'b0;
			pending_bytes = {pending_bytes, it};
			// occasional empty item inside the message
			if (mode == 0 && $urandom_range(0, 15) == 0) begin
				it.byte_valid = 1'b0;
				pending_bytes = {pending_bytes, it};
			end
		end
		it.data_byte = 8'($urandom);
		it.byte_valid = (len > 0) || $urandom_range(0, 1);
		if (len == 0) it.byte_valid = 1'b0;
		it.end_of_message = 1'b1;
		pending_bytes = {pending_bytes, it};
	endtask

	// driver: change inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					byte_item_t it;
					it = pending_bytes.pop_front();
					s_axis_tdata <= it.data_byte;
					s_axis_tuser <= it.byte_valid;
					s_axis_tlast <= it.end_of_message;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: sample at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready)
				hash_item({s_axis_tdata, s_axis_tuser[0], s_axis_tlast});
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digest.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest word %h idx %0d", m_axis_tdata, m_axis_tuser);
				end else begin
					digest_item_t e;
					e = expected_digest.pop_front();
					if (e.digest_word !== m_axis_tdata || e.word_index !== m_axis_tuser
						|| e.last_word !== m_axis_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
								e.digest_word, e.word_index, e.last_word,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
		end
	end

	// watchdog: no handshake for too long ends the run
	always @(posedge clk) begin
		if (stall_cycles > WatchdogLimit) begin
			$display("[sha256_stream_hasher] ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_bytes.size() > 0 || s_axis_tvalid || expected_digest.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		hash_state = sha_pkg::H0;
		block_bytes = 0;
		bit_count = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: empty message, one byte, padding borders, extremes
		queue_message(0, 0);
		queue_message(1, 1);
		queue_message(3, 2);
		queue_message(3, 0);
		queue_message(1, 0);
		queue_message(0, 0);
		wait_drained();
		queue_message(55, 1);
		queue_message(56, 0);
		wait_drained();

		// receiver holds off while a full-block message waits behind the digest
		send_idle_pct = 0;
		hold_off = 1'b1;
		queue_message(10, 0);
		queue_message(63, 1);
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 26 : 0;
			for (int m = 0; m < 2; m++)
				queue_message($urandom_range(0, 6), 0);
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && expected_digest.size() == 0)
			$display("[sha256_stream_hasher] OK");
		else
			$display("[sha256_stream_hasher] ERROR");
		$finish;
	end
endmodule
